/* rtl/ovn_pkg.sv */
package ovn_pkg;

   // Default seed table depth; must be a power of two.
   localparam int MAP_POINTS_DEF = 256;

   // Octave limits and the weight of the coarsest octave (2^7).
   localparam logic [3:0] OCTAVES_MAX      = 4'd8;
   localparam logic [3:0] OCTAVES_MIN      = 4'd1;
   localparam logic [3:0] OCTAVES_RESET    = 4'd8;
   localparam logic [2:0] TOP_WEIGHT_SHIFT = 3'd7;

   // Action codes of an input item.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic        action;
      logic [7:0]  index;
      logic [15:0] seed_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  position;
      logic [15:0] noise_value;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       start;     // latch the query and clear the accumulator
      logic       rd_en;     // issue one seed read
      logic [3:0] rd_k;      // read number: octave in [3:1], next-seed select in [0]
      logic       div_load;  // load the normalizing divider
      logic       div_step;  // one quotient bit
      logic       out_load;  // move the quotient into the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [3:0] n_oct;     // octave count in use for the current query
      logic       out_free;  // the result register can take a new result
   } sts_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Limits the configured octave count to the legal range.
   function automatic logic [3:0] oct_clamp(input logic [3:0] n);
      logic [3:0] r;
      if (n < OCTAVES_MIN) begin
         r = OCTAVES_MIN;
      end else if (n > OCTAVES_MAX) begin
         r = OCTAVES_MAX;
      end else begin
         r = n;
      end
      return r;
   endfunction

endpackage

/* rtl/ovn_ctrl.sv */
module ovn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_action,
   output logic             req_ready,
   input  ovn_pkg::sts_type sts,
   output ovn_pkg::cmd_type cmd
);

   ovn_pkg::state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               last_rd;

   assign last_rd = (cnt_ff == (({1'b0, sts.n_oct}) << 1) - 5'd1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.rd_k     = cnt_ff[3:0];
      case (state_ff)
         ovn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_action == ovn_pkg::ACT_QUERY)) begin
               cmd.start = 1'b1;
               cnt_in    = 5'd0;
               state_in  = ovn_pkg::ST_READ;
            end
         end
         ovn_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            if (last_rd) begin
               cnt_in   = 5'd0;
               state_in = ovn_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ovn_pkg::ST_DRAIN: begin
            // The drain state lets the last product reach the accumulator.
            if (cnt_ff == 5'd2) begin
               cmd.div_load = 1'b1;
               cnt_in       = 5'd0;
               state_in     = ovn_pkg::ST_DIV;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ovn_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'd15) begin
               cnt_in   = 5'd0;
               state_in = ovn_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ovn_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ovn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ovn_pkg::ST_IDLE;
            cnt_in   = 5'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ovn_pkg::ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/ovn_dpath.sv */
module ovn_dpath #(
   parameter int MAP_POINTS = ovn_pkg::MAP_POINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ovn_pkg::req_type req_data,
   input  logic             req_fire,
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata,
   input  ovn_pkg::cmd_type cmd,
   output ovn_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ovn_pkg::rsp_type rsp_data
);

   localparam int AW    = $clog2(MAP_POINTS);
   localparam int CW    = AW + 1;
   localparam int PW    = 16 + CW;
   localparam int ACC_W = AW + 24;
   localparam int SH_W  = $clog2(AW + 9);

   logic [15:0]      mem [MAP_POINTS];

   logic [3:0]       csr_oct_ff;
   logic [3:0]       n_ff;
   logic [AW-1:0]    idx_ff;
   logic [7:0]       pos_ff;

   // Read address generation.
   logic [2:0]       oct_j;
   logic [3:0]       ssh;
   logic [AW-1:0]    lo_mask, base, pitch, nxt, offs, rd_addr;
   logic [CW-1:0]    coef;
   logic [2:0]       wsh;

   logic [15:0]      rd_data_ff;
   logic [CW-1:0]    coef_ff;
   logic [2:0]       wsh1_ff, wsh2_ff;
   logic             s1_valid_ff, s2_valid_ff;
   logic [PW-1:0]    prod_ff;
   logic [ACC_W-1:0] acc_ff;

   // Normalizing divider.
   logic [SH_W-1:0]  shamt;
   logic [23:0]      dividend;
   logic [7:0]       divisor;
   logic [7:0]       rem_ff;
   logic [15:0]      quo_ff;
   logic [8:0]       trial, diff;
   logic             ge;

   logic             rsp_valid_ff;
   ovn_pkg::rsp_type rsp_data_ff;

   always_comb begin
      oct_j   = cmd.rd_k[3:1];
      ssh     = ({1'b0, oct_j} > 4'(AW)) ? 4'(AW) : {1'b0, oct_j};
      lo_mask = {AW{1'b1}} >> ssh;
      base    = idx_ff & ~lo_mask;
      pitch   = lo_mask + AW'(1);
      nxt     = base + pitch;
      offs    = (idx_ff & lo_mask) << ssh;
      rd_addr = cmd.rd_k[0] ? nxt : base;
      coef    = cmd.rd_k[0] ? {1'b0, offs} : (CW'(MAP_POINTS) - {1'b0, offs});
      wsh     = ovn_pkg::TOP_WEIGHT_SHIFT - oct_j;
   end

   always_comb begin
      shamt    = SH_W'(AW) + SH_W'(8) - SH_W'(n_ff);
      dividend = 24'(acc_ff >> shamt);
      divisor  = 8'((9'd1 << n_ff) - 9'd1);
      trial    = {rem_ff, quo_ff[15]};
      ge       = (trial >= {1'b0, divisor});
      diff     = trial - {1'b0, divisor};
   end

   // Seed table.
   always_ff @(posedge clock) begin
      if (req_fire && (req_data.action == ovn_pkg::ACT_WRITE)) begin
         mem[AW'(req_data.index)] <= req_data.seed_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff <= AW'(req_data.index);
         pos_ff <= req_data.index;
      end
      coef_ff <= coef;
      wsh1_ff <= wsh;
      wsh2_ff <= wsh1_ff;
      prod_ff <= PW'(rd_data_ff) * PW'(coef_ff);
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + (ACC_W'(prod_ff) << wsh2_ff);
      end
      if (cmd.div_load) begin
         rem_ff <= dividend[23:16];
         quo_ff <= dividend[15:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[7:0] : trial[7:0];
         quo_ff <= {quo_ff[14:0], ge};
      end
      if (cmd.out_load) begin
         rsp_data_ff.position    <= pos_ff;
         rsp_data_ff.noise_value <= quo_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_oct_ff   <= ovn_pkg::OCTAVES_RESET;
         n_ff         <= ovn_pkg::OCTAVES_MAX;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_oct_ff <= csr_wdata;
         end
         if (cmd.start) begin
            n_ff <= ovn_pkg::oct_clamp(csr_oct_ff);
         end
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.n_oct    = n_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // The accumulator must hold every term before normalization starts.
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("divider loaded while products are still in flight");

   // Reads never go past the last octave in use.
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> ({1'b0, cmd.rd_k} < ({1'b0, n_ff} << 1)))
      else $error("seed read beyond the octave count");

   // Long division keeps its partial remainder below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < divisor))
      else $error("divider remainder out of range");

   // A loaded result is presented on the next cycle.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid_ff && (rsp_data_ff.noise_value == $past(quo_ff))))
      else $error("result register did not take the quotient");

endmodule

/* rtl/octave_value_noise_1d_core.sv */
// A query passes through the seed reads (two per octave on the single memory read port),
// a drain of the product pipeline, the bit-serial 16-step divider and the result register.
// A seed write completes in the cycle of its transfer; writes go one per cycle while no query
// is in progress, and a new query is taken only once the last result has been loaded.
// Reset (synchronous, active high) clears the controller, the result valid flag and sets the
// octave count to 8; the seed table is not cleared and must be written before it is queried.
module octave_value_noise_1d_core #(
   parameter int MAP_POINTS = ovn_pkg::MAP_POINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ovn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ovn_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata
);

   // The block sums up to eight octaves of linearly interpolated value noise.
   // Octave j uses a lattice pitch of MAP_POINTS >> j (at least one) and a weight
   // of 2^(7-j). Every octave term is scaled to the common denominator
   // MAP_POINTS, so it becomes (MAP_POINTS - off) * seed[base] + off * seed[next],
   // where off is the offset inside the cell scaled up to the full table.
   // The two products of one octave go through a single multiplier, one seed
   // per cycle, and are shifted by the octave weight into a wide accumulator.
   //
   // The total weight is 2^(8-N) * (2^N - 1). Dividing by MAP_POINTS and by
   // 2^(8-N) is a shift; the remaining divisor 2^N - 1 is handled by a
   // restoring divider that produces one quotient bit per cycle. Since the
   // result is a weighted mean of 16-bit seeds, the quotient always fits in
   // 16 bits, so the division needs exactly 16 steps.
   //
   // Seed writes go straight into the table during the input transfer. The
   // result register lets a finished result wait for its transfer while the
   // block goes back to idle and takes further writes or a new query.

   ovn_pkg::cmd_type cmd;
   ovn_pkg::sts_type sts;
   logic             req_fire;

   assign req_fire = req_valid && req_ready;

   ovn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ovn_dpath #(
      .MAP_POINTS (MAP_POINTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_fire  (req_fire),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
